// ----- design/sha_pkg.sv -----
package sha_pkg;

    localparam int BlockBytes = 64;
    localparam int LenPos     = 56;
    localparam int Rounds     = 64;
    localparam int DigestWords = 8;
    localparam logic [7:0] PadByte = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load_byte;
        logic       pad_write;
        logic       pad_mark;
        logic       start_comp;
        logic       init_hash;
        logic       emit_load;
    } cmd_t;

    typedef struct packed {
        logic       block_full;
        logic       comp_done;
        logic       pad_second;
    } status_t;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- design/sha_datapath.sv -----
module sha_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  sha_pkg::cmd_t     cmd,
    input  logic [7:0]        data_byte,
    output sha_pkg::status_t  status,
    output logic [31:0]       digest_word,
    output logic [2:0]        word_index,
    output logic              last_word,
    output logic              out_valid,
    input  logic              out_ready
);

    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  round_reg;
    logic        comp_reg;
    logic        emit_reg;
    logic [2:0]  idx_reg;
    logic        second_reg;

    logic [31:0] w_new, wt, t1, t2, s0, s1, e, a;
    logic [7:0]  pad_byte;
    logic [31:0] wr_word;
    logic [3:0]  wsel;
    logic [1:0]  bsel;
    logic [5:0]  lbit;

    assign s0 = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19)
              ^ (w_reg[14] >> 10);
    assign w_new = s1 + w_reg[9] + s0 + w_reg[0];
    assign wt = w_reg[0];
    assign e = v_reg[4];
    assign a = v_reg[0];
    assign t1 = v_reg[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
              + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha_pkg::RoundK[round_reg] + wt;
    assign t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
              + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign lbit = {~fill_reg[2:0], 3'b111};

    always_comb begin
        pad_byte = 8'h00;
        if (cmd.load_byte) begin
            pad_byte = data_byte;
        end else if (cmd.pad_mark) begin
            pad_byte = sha_pkg::PadByte;
        end else if (second_reg && fill_reg >= 6'(sha_pkg::LenPos)) begin
            pad_byte = len_reg[lbit -: 8];
        end
    end

    assign status.pad_second = second_reg;
    assign status.block_full = (fill_reg == 6'd63);
    assign status.comp_done = comp_reg && (round_reg == 6'd63);

    assign wsel = fill_reg[5:2];
    assign bsel = fill_reg[1:0];

    always_comb begin
        wr_word = w_reg[wsel];
        case (bsel)
            2'd0:    wr_word[31:24] = pad_byte;
            2'd1:    wr_word[23:16] = pad_byte;
            2'd2:    wr_word[15:8]  = pad_byte;
            default: wr_word[7:0]   = pad_byte;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_next[i] = w_reg[i];
        end
        if (comp_reg) begin
            for (int i = 0; i < 15; i++) begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = w_new;
        end else if (cmd.load_byte || cmd.pad_write) begin
            w_next[wsel] = wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) begin
            w_reg[i] <= w_next[i];
        end
        if (cmd.start_comp) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (comp_reg) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha_pkg::InitHash[i];
            end
            fill_reg   <= '0;
            len_reg    <= '0;
            round_reg  <= '0;
            comp_reg   <= 1'b0;
            emit_reg   <= 1'b0;
            idx_reg    <= '0;
            second_reg <= 1'b0;
        end else begin
            if (cmd.load_byte) begin
                fill_reg <= fill_reg + 6'd1;
                len_reg  <= len_reg + 64'd8;
            end else if (cmd.pad_write) begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.start_comp) begin
                comp_reg  <= 1'b1;
                round_reg <= '0;
            end else if (comp_reg) begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    comp_reg <= 1'b0;
                    h_reg[0] <= h_reg[0] + (t1 + t2);
                    h_reg[1] <= h_reg[1] + v_reg[0];
                    h_reg[2] <= h_reg[2] + v_reg[1];
                    h_reg[3] <= h_reg[3] + v_reg[2];
                    h_reg[4] <= h_reg[4] + v_reg[3] + t1;
                    h_reg[5] <= h_reg[5] + v_reg[4];
                    h_reg[6] <= h_reg[6] + v_reg[5];
                    h_reg[7] <= h_reg[7] + v_reg[6];
                end
            end
            if (cmd.emit_load) begin
                emit_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (emit_reg && out_ready) begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7) begin
                    emit_reg <= 1'b0;
                end
            end
            if (cmd.init_hash) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= sha_pkg::InitHash[i];
                end
                len_reg    <= '0;
                fill_reg   <= '0;
                second_reg <= 1'b0;
            end else if (cmd.pad_write && fill_reg == 6'(sha_pkg::LenPos - 1)) begin
                second_reg <= 1'b1;
            end
        end
    end

    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);
    assign out_valid   = emit_reg;

endmodule

// ----- design/sha_ctrl.sv -----
module sha_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_byte_present,
    input  logic              s_end_of_message,
    input  sha_pkg::status_t  status,
    input  logic              out_busy,
    output sha_pkg::cmd_t     cmd
);

    sha_pkg::state_t state_reg, state_next;
    logic            final_reg, final_next;
    logic            pad80_reg, pad80_next;
    logic            accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        final_next = final_reg;
        pad80_next = pad80_reg;
        case (state_reg)
            sha_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_byte_present && status.block_full) begin
                        state_next = sha_pkg::ST_COMP;
                        final_next = s_end_of_message;
                        pad80_next = s_end_of_message;
                    end else if (s_end_of_message) begin
                        state_next = sha_pkg::ST_PAD;
                        final_next = 1'b1;
                        pad80_next = 1'b1;
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                pad80_next = 1'b0;
                if (status.block_full) begin
                    state_next = sha_pkg::ST_COMP;
                end
            end
            sha_pkg::ST_COMP: begin
                if (status.comp_done) begin
                    if (!final_reg) begin
                        state_next = sha_pkg::ST_IDLE;
                    end else if (pad80_reg || !status.pad_second) begin
                        state_next = sha_pkg::ST_PAD;
                    end else begin
                        state_next = sha_pkg::ST_EMIT;
                    end
                end
            end
            sha_pkg::ST_EMIT: begin
                if (!out_busy) begin
                    state_next = sha_pkg::ST_IDLE;
                    final_next = 1'b0;
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd = '0;
        case (state_reg)
            sha_pkg::ST_IDLE: begin
                s_ready = !out_busy;
                cmd.load_byte = accept && s_byte_present;
            end
            sha_pkg::ST_PAD: begin
                cmd.pad_write  = 1'b1;
                cmd.pad_mark   = pad80_reg;
                cmd.start_comp = status.block_full;
            end
            sha_pkg::ST_COMP: begin
                cmd.emit_load = status.comp_done && final_reg && !pad80_reg
                              && status.pad_second;
            end
            sha_pkg::ST_EMIT: begin
                cmd.init_hash = !out_busy;
            end
            default: ;
        endcase
        if (state_reg == sha_pkg::ST_IDLE && accept && s_byte_present && status.block_full) begin
            cmd.start_comp = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha_pkg::ST_IDLE;
            final_reg <= 1'b0;
            pad80_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            final_reg <= final_next;
            pad80_reg <= pad80_next;
        end
    end

endmodule

// ----- design/sha256_stream_hasher_unit.sv -----
// SHA-256 over a byte stream.
// Input channel s_: one request per cycle while s_ready is high; a request
// carries s_data_byte when s_byte_present is high; s_end_of_message closes
// the message, after its byte if any. Result channel m_: eight words
// m_digest_word, index m_word_index, m_last_word on the eighth.
// A byte that fills the 64-byte block holds the input while the shared round
// unit runs one round a cycle. Ending a message writes padding one byte a
// cycle up to the end of the block (twice when fewer than nine bytes are
// free), runs 64 rounds per padded block, then presents the digest words.
// The input stays blocked until all eight words are taken and in the cycle
// after that, while the hash state reinitialises; a stalled receiver holds
// the current word.
// Reset returns the initial hash values, zero fill and zero bit length.
module sha256_stream_hasher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    sha_pkg::cmd_t    cmd;
    sha_pkg::status_t status;

    sha_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_present   (s_byte_present),
        .s_end_of_message (s_end_of_message),
        .status           (status),
        .out_busy         (m_valid),
        .cmd              (cmd)
    );

    sha_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_data_byte),
        .status      (status),
        .digest_word (m_digest_word),
        .word_index  (m_word_index),
        .last_word   (m_last_word),
        .out_valid   (m_valid),
        .out_ready   (m_ready)
    );

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken during digest output");
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_word |-> m_word_index == 3'd7) else $error("last word index");
    a_emit_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_word |=> !m_valid) else $error("extra digest word");

endmodule
